/* src/irpd_pkg.sv */
// Shared types, register indexes and helpers for the IR pulse-code decoder.
package irpd_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DurW     = 16;
  localparam int unsigned TolW     = 12;
  localparam int unsigned CodeW    = 32;
  localparam int unsigned InTdataW  = 24;
  localparam int unsigned OutTdataW = 40;

  typedef enum logic [CfgAddrW-1:0] {
    CfgHeaderMark  = 3'd0,
    CfgHeaderSpace = 3'd1,
    CfgHeaderTol   = 3'd2,
    CfgGap         = 3'd3,
    CfgGapTol      = 3'd4,
    CfgZeroTime    = 3'd5,
    CfgOneTime     = 3'd6,
    CfgBitTol      = 3'd7
  } irpd_cfg_idx_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StNoHeader = 3'd1,
    StBadGap   = 3'd2,
    StBadBit   = 3'd3,
    StTooShort = 3'd4,
    StTooMany  = 3'd5
  } irpd_status_e;

  typedef struct packed {
    logic [DurW-1:0] header_mark;
    logic [DurW-1:0] header_space;
    logic [TolW-1:0] header_tol;
    logic [DurW-1:0] gap;
    logic [TolW-1:0] gap_tol;
    logic [DurW-1:0] zero_time;
    logic [DurW-1:0] one_time;
    logic [TolW-1:0] bit_tol;
  } irpd_cfg_t;

  // true when |expect - actual| < tol
  function automatic logic near_to(input logic [DurW-1:0] expect_v,
                                   input logic [DurW-1:0] actual_v,
                                   input logic [TolW-1:0] tol_v);
    logic [DurW-1:0] diff;
    diff = (expect_v > actual_v) ? (expect_v - actual_v) : (actual_v - expect_v);
    return diff < {{(DurW-TolW){1'b0}}, tol_v};
  endfunction

endpackage

/* src/irpd_cfg_regs.sv */
// Timing and tolerance configuration registers.
module irpd_cfg_regs
  import irpd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output irpd_cfg_t           cfg_o
);

  irpd_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (irpd_cfg_idx_e'(cfg_addr_i))
        CfgHeaderMark:  cfg_d.header_mark  = cfg_data_i;
        CfgHeaderSpace: cfg_d.header_space = cfg_data_i;
        CfgHeaderTol:   cfg_d.header_tol   = cfg_data_i[TolW-1:0];
        CfgGap:         cfg_d.gap          = cfg_data_i;
        CfgGapTol:      cfg_d.gap_tol      = cfg_data_i[TolW-1:0];
        CfgZeroTime:    cfg_d.zero_time    = cfg_data_i;
        CfgOneTime:     cfg_d.one_time     = cfg_data_i;
        CfgBitTol:      cfg_d.bit_tol      = cfg_data_i[TolW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_mark  <= 16'd9000;
      cfg_q.header_space <= 16'd4500;
      cfg_q.header_tol   <= 12'd200;
      cfg_q.gap          <= 16'd600;
      cfg_q.gap_tol      <= 12'd110;
      cfg_q.zero_time    <= 16'd600;
      cfg_q.one_time     <= 16'd1600;
      cfg_q.bit_tol      <= 12'd400;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/irpd_frame_core.sv */
// Per-frame state: header check, gap check, bit classification and status.
module irpd_frame_core
  import irpd_pkg::*;
#(
  parameter int unsigned MAX_READINGS = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  irpd_cfg_t        cfg_i,
  input  logic             step_i,
  input  logic             level_i,
  input  logic [DurW-1:0]  duration_i,
  input  logic             last_i,
  output logic [CodeW-1:0] code_o,
  output irpd_status_e     status_o
);

  localparam int unsigned CntW = $clog2(MAX_READINGS + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DurW-1:0]  first_q, first_d;
  logic [CodeW-1:0] code_q, code_d;
  irpd_status_e     err_q, err_d;

  logic [CntW-2:0]  bitno;
  logic             is_zero, is_one, hdr_ok;

  assign bitno   = cnt_q[CntW-1:1] - 1'b1;
  assign is_zero = near_to(cfg_i.zero_time, duration_i, cfg_i.bit_tol);
  assign is_one  = near_to(cfg_i.one_time, duration_i, cfg_i.bit_tol);
  assign hdr_ok  = near_to(cfg_i.header_mark, first_q, cfg_i.header_tol) &&
                   near_to(cfg_i.header_space, duration_i, cfg_i.header_tol);

  always_comb begin
    cnt_d    = cnt_q;
    first_d  = first_q;
    code_d   = code_q;
    err_d    = err_q;
    status_o = err_q;
    code_o   = '0;

    if (cnt_q >= CntW'(MAX_READINGS)) begin
      if (err_q == StOk) err_d = StTooMany;
    end else if (cnt_q == '0) begin
      first_d = duration_i;
    end else if (cnt_q == CntW'(1)) begin
      if (!hdr_ok) err_d = StNoHeader;
    end else if (err_q == StOk) begin
      if (!level_i) begin
        if (!near_to(cfg_i.gap, duration_i, cfg_i.gap_tol)) err_d = StBadGap;
      end else if (!is_zero && !is_one) begin
        err_d = StBadBit;
      end else if (32'(bitno) >= 32'd32) begin
        err_d = StTooMany;
      end else begin
        code_d = code_q | ((is_zero ? 32'd0 : 32'd1) << bitno);
      end
    end

    if (cnt_q < CntW'(MAX_READINGS)) cnt_d = cnt_q + 1'b1;

    if (cnt_d < CntW'(2) || err_d == StNoHeader) begin
      status_o = StNoHeader;
    end else if (cnt_d <= CntW'(4)) begin
      status_o = StTooShort;
    end else begin
      status_o = err_d;
    end
    code_o = (status_o == StOk) ? code_d : '0;

    if (last_i) begin
      cnt_d   = '0;
      first_d = '0;
      code_d  = '0;
      err_d   = StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      first_q <= '0;
      code_q  <= '0;
      err_q   <= StOk;
    end else if (step_i) begin
      cnt_q   <= cnt_d;
      first_q <= first_d;
      code_q  <= code_d;
      err_q   <= err_d;
    end
  end

endmodule

/* src/ir_pulse_code_decoder.sv */
// IR pulse-code decoder top level: input register, frame core, result register.
//
//   channel   dir  handshake             payload
//   s_axis    in   tvalid/tready         tdata{duration_us,level}, tlast = last
//   m_axis    out  tvalid/tready         tdata{status,code}
//   cfg       in   cfg_we_i              cfg_addr_i, cfg_data_i
//
// One reading per cycle unless a closing reading is held in the input register;
// a result is written to the result register as its closing reading leaves it.
// The frame core compares and accumulates each reading as it leaves the input register.
// A reading that closes a frame waits in the input register while the result
// register is full and not taken; other readings pass regardless.
// Reset clears all frame state and loads the default timing registers.
module ir_pulse_code_decoder
  import irpd_pkg::*;
#(
  parameter int unsigned MAX_READINGS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // [0] level, [16:1] duration_us
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,   // [31:0] code, [34:32] status
  input  logic                 cfg_we_i,
  input  logic [CfgAddrW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  irpd_cfg_t cfg;

  logic            in_vld_q;
  logic            in_level_q, in_last_q;
  logic [DurW-1:0] in_dur_q;
  logic            advance;

  logic            out_vld_q;
  logic [CodeW-1:0] out_code_q;
  irpd_status_e    out_status_q;

  logic [CodeW-1:0] res_code;
  irpd_status_e     res_status;

  irpd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign advance = in_vld_q && (!in_last_q || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_level_q <= s_axis_tdata[0];
      in_dur_q   <= s_axis_tdata[DurW:1];
      in_last_q  <= s_axis_tlast;
    end
  end

  irpd_frame_core #(
    .MAX_READINGS (MAX_READINGS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .step_i     (advance),
    .level_i    (in_level_q),
    .duration_i (in_dur_q),
    .last_i     (in_last_q),
    .code_o     (res_code),
    .status_o   (res_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_code_q   <= res_code;
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutTdataW-CodeW-3){1'b0}}, out_status_q, out_code_q};

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the IR pulse-code decoder stream block.
module tb_top;
  import irpd_pkg::*;

  localparam int MaxReadings = 256;
  localparam int SettleCycles = 8;

  typedef struct packed {
    logic            level;
    logic [DurW-1:0] dur;
    logic            last;
  } reading_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    irpd_status_e     status;
  } frame_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;  // [0] level, [16:1] duration_us
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;       // [31:0] code, [34:32] status
  logic                 cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0]  cfg_addr_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  ir_pulse_code_decoder #(
    .MAX_READINGS(MaxReadings)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  reading_t      pend_q[$];
  frame_result_t frame_q[$];
  reading_t      cur_rd;
  int            n_queued = 0;
  int            n_errors = 0;
  bit            calm = 1'b0;

  // decoder shadow: timing registers and frame state
  irpd_cfg_t     timing;
  int            rd_cnt;
  logic [DurW-1:0] mark_dur;
  logic [CodeW-1:0] code_acc;
  irpd_status_e  frame_err;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("ir_pulse_code_decoder regression: fail");
    $finish;
  end

  function automatic bit within_tol(logic [DurW-1:0] a, logic [DurW-1:0] b,
                                    logic [TolW-1:0] tol);
    int d;
    d = (a > b) ? a - b : b - a;
    return d < tol;
  endfunction

  function automatic logic [DurW-1:0] jitter(int nom, int tol);
    int off;
    if (tol <= 1) return nom[DurW-1:0];
    off = $urandom_range(0, 2 * tol - 2);
    off = off - (tol - 1) + nom;
    if (off < 0) off = 0;
    if (off > 65535) off = 65535;
    return off[DurW-1:0];
  endfunction

  task automatic clear_frame();
    rd_cnt    = 0;
    mark_dur  = '0;
    code_acc  = '0;
    frame_err = StOk;
  endtask

  task automatic decode_reading(input reading_t r);
    int idx;
    int bitno;
    frame_result_t res;
    idx = rd_cnt;
    if (idx >= MaxReadings) begin
      if (frame_err == StOk) frame_err = StTooMany;
    end else if (idx == 0) begin
      mark_dur = r.dur;
    end else if (idx == 1) begin
      if (!(within_tol(timing.header_mark, mark_dur, timing.header_tol) &&
            within_tol(timing.header_space, r.dur, timing.header_tol)))
        frame_err = StNoHeader;
    end else if (frame_err == StOk) begin
      if (!r.level) begin
        if (!within_tol(timing.gap, r.dur, timing.gap_tol)) frame_err = StBadGap;
      end else begin
        bitno = idx / 2 - 1;
        if (within_tol(timing.zero_time, r.dur, timing.bit_tol)) begin
          if (bitno >= 32) frame_err = StTooMany;
        end else if (within_tol(timing.one_time, r.dur, timing.bit_tol)) begin
          if (bitno >= 32) frame_err = StTooMany;
          else code_acc[bitno] = 1'b1;
        end else begin
          frame_err = StBadBit;
        end
      end
    end
    if (idx < MaxReadings) rd_cnt = idx + 1;
    if (r.last) begin
      if (rd_cnt < 2 || frame_err == StNoHeader) res.status = StNoHeader;
      else if (rd_cnt <= 4) res.status = StTooShort;
      else res.status = frame_err;
      res.code = (res.status == StOk) ? code_acc : '0;
      frame_q.push_back(res);
      clear_frame();
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_reading(cur_rd);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pend_q.size() > 0 && (calm || $urandom_range(0, 99) >= 27)) begin
          cur_rd = pend_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(InTdataW-DurW-1){1'b0}}, cur_rd.dur, cur_rd.level};
          s_axis_tlast  <= cur_rd.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (frame_q.size() == 0) begin
          $display("%0t: unexpected transfer, actual code %h status %0d", $time,
                   m_axis_tdata[31:0], m_axis_tdata[34:32]);
          n_errors++;
        end else begin
          want = frame_q.pop_front();
          if (m_axis_tdata[31:0] !== want.code) begin
            $display("%0t: code mismatch, expected %h actual %h", $time, want.code,
                     m_axis_tdata[31:0]);
            n_errors++;
          end
          if (m_axis_tdata[34:32] !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d", $time,
                     want.status, m_axis_tdata[34:32]);
            n_errors++;
          end
        end
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 27);
    end
  end

  task automatic push_reading(logic lvl, logic [DurW-1:0] d, logic lst);
    reading_t r;
    r.level = lvl;
    r.dur   = d;
    r.last  = lst;
    pend_q.push_back(r);
    n_queued++;
  endtask

  task automatic push_frame(int nbits, int bad_at, bit trail);
    int total;
    logic lvl;
    logic [DurW-1:0] d;
    total = 2 + 2 * nbits + trail;
    for (int i = 0; i < total; i++) begin
      if (i < 2) begin
        lvl = $urandom_range(0, 1);
        d = (i == 0) ? jitter(timing.header_mark, timing.header_tol)
                     : jitter(timing.header_space, timing.header_tol);
      end else if (i % 2 == 0) begin
        lvl = 1'b0;
        d = jitter(timing.gap, timing.gap_tol);
      end else begin
        lvl = 1'b1;
        d = jitter($urandom_range(0, 1) ? timing.one_time : timing.zero_time,
                   timing.bit_tol);
      end
      if (i == bad_at) begin
        d = $urandom_range(0, 65535);
        if ($urandom_range(0, 1)) lvl = ~lvl;
      end
      push_reading(lvl, d, i == total - 1);
    end
  endtask

  // header followed by separators only, running past the reading limit
  task automatic push_overlong(int total);
    for (int i = 0; i < total; i++) begin
      if (i < 2)
        push_reading(1'b1, (i == 0) ? timing.header_mark : timing.header_space, 1'b0);
      else
        push_reading(1'b0, jitter(timing.gap, timing.gap_tol), i == total - 1);
    end
  endtask

  task automatic push_noise();
    int len;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++)
      push_reading($urandom_range(0, 1), $urandom_range(0, 65535), i == len - 1);
  endtask

  task automatic fill_random(int upto);
    int sel;
    int nbits;
    while (n_queued < upto) begin
      sel = $urandom_range(0, 9);
      nbits = (sel < 5) ? 32 : (sel == 5) ? 33 : $urandom_range(0, 34);
      sel = $urandom_range(0, 99);
      if (sel < 60) push_frame(nbits, -1, $urandom_range(0, 3) == 0);
      else if (sel < 85) push_frame(nbits, $urandom_range(0, 2 * nbits + 1), 1'b0);
      else push_noise();
    end
  endtask

  task automatic write_reg(irpd_cfg_idx_e idx, logic [CfgDataW-1:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= v;
    case (idx)
      CfgHeaderMark:  timing.header_mark  = v;
      CfgHeaderSpace: timing.header_space = v;
      CfgHeaderTol:   timing.header_tol   = v[TolW-1:0];
      CfgGap:         timing.gap          = v;
      CfgGapTol:      timing.gap_tol      = v[TolW-1:0];
      CfgZeroTime:    timing.zero_time    = v;
      CfgOneTime:     timing.one_time     = v;
      CfgBitTol:      timing.bit_tol      = v[TolW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic [CfgDataW-1:0] hm, logic [CfgDataW-1:0] hs,
                           logic [CfgDataW-1:0] ht, logic [CfgDataW-1:0] gp,
                           logic [CfgDataW-1:0] gt, logic [CfgDataW-1:0] zt,
                           logic [CfgDataW-1:0] ot, logic [CfgDataW-1:0] bt);
    write_reg(CfgHeaderMark, hm);
    write_reg(CfgHeaderSpace, hs);
    write_reg(CfgHeaderTol, ht);
    write_reg(CfgGap, gp);
    write_reg(CfgGapTol, gt);
    write_reg(CfgZeroTime, zt);
    write_reg(CfgOneTime, ot);
    write_reg(CfgBitTol, bt);
  endtask

  // sender holds off until every frame result is back and the pipe is empty
  task automatic drain();
    do @(posedge clk_i);
    while (pend_q.size() != 0 || s_axis_tvalid || frame_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    timing = '{header_mark: 16'd9000, header_space: 16'd4500, header_tol: 12'd200,
               gap: 16'd600, gap_tol: 12'd110, zero_time: 16'd600,
               one_time: 16'd1600, bit_tol: 12'd400};
    clear_frame();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single reading: no header
    push_reading(1'b1, 16'd0, 1'b1);
    // two readings, header mark out of range
    push_reading(1'b0, 16'hFFFF, 1'b0);
    push_reading(1'b1, 16'd4500, 1'b1);
    // good header but only four readings
    push_reading(1'b1, 16'd9000, 1'b0);
    push_reading(1'b0, 16'd4500, 1'b0);
    push_reading(1'b0, 16'd600, 1'b0);
    push_reading(1'b1, 16'd1600, 1'b1);
    // bad separator
    push_reading(1'b1, 16'd9199, 1'b0);
    push_reading(1'b0, 16'd4301, 1'b0);
    push_reading(1'b0, 16'd600, 1'b0);
    push_reading(1'b1, 16'd1600, 1'b0);
    push_reading(1'b0, 16'hFFFF, 1'b1);
    // bit time matching neither symbol
    push_reading(1'b1, 16'd9000, 1'b0);
    push_reading(1'b0, 16'd4500, 1'b0);
    push_reading(1'b0, 16'd709, 1'b0);
    push_reading(1'b1, 16'd1100, 1'b0);
    push_reading(1'b0, 16'd600, 1'b1);
    // short clean frame, code 3'b101
    push_reading(1'b1, 16'd9000, 1'b0);
    push_reading(1'b0, 16'd4500, 1'b0);
    push_reading(1'b0, 16'd491, 1'b0);
    push_reading(1'b1, 16'd1999, 1'b0);
    push_reading(1'b0, 16'd600, 1'b0);
    push_reading(1'b1, 16'd201, 1'b0);
    push_reading(1'b0, 16'd600, 1'b0);
    push_reading(1'b1, 16'd1201, 1'b1);
    fill_random(200);
    push_overlong(260);
    drain();

    calm = 1'b1;
    write_all($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 65535));
    fill_random(620);
    drain();
    calm = 1'b0;

    write_all(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0FFF, 16'd0, 16'hFFFF, 16'hFFFF);
    fill_random(740);
    drain();

    write_reg(CfgHeaderTol, 16'd0);
    write_reg(CfgGapTol, 16'd0);
    write_reg(CfgBitTol, 16'd0);
    fill_random(840);
    drain();

    write_all(16'd9000, 16'd4500, 16'd200, 16'd600, 16'd110, 16'd1000, 16'd1200,
              16'd4095);
    fill_random(940);
    drain();

    write_all(16'd9000, 16'd4500, 16'd200, 16'd600, 16'd110, 16'd600, 16'd1600,
              16'd400);
    push_overlong(258);
    fill_random(1250);
    drain();
    repeat (20) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("ir_pulse_code_decoder regression: pass");
    end else begin
      $display("ir_pulse_code_decoder regression: fail");
    end
    $finish;
  end

endmodule

/* ir_pulse_code_decoder.f */
src/irpd_pkg.sv
src/irpd_cfg_regs.sv
src/irpd_frame_core.sv
src/ir_pulse_code_decoder.sv
dv/tb_top.sv
